FILE: sv/spmf_pkg.sv
// shared types, codes and default sizes for the strict priority multi-fifo
package spmf_pkg;

  localparam int LEVELS_DEF       = 8;
  localparam int LEVEL_DEPTH_DEF  = 16;
  localparam int HANDLE_WIDTH_DEF = 16;

  localparam int ACTION_W     = 2;
  localparam int LEVEL_W      = 3;
  localparam int HANDLE_IO_W  = 16;
  localparam int STATUS_W     = 2;
  localparam int TOTAL_IO_W   = 8;
  // wide enough to compare a level code against any allowed level count
  localparam int LEVEL_CMP_W  = 7;

  typedef enum logic [ACTION_W-1:0] {
    ACT_ENQ   = 2'd0,
    ACT_DEQ   = 2'd1,
    ACT_PEEK  = 2'd2,
    ACT_CLEAR = 2'd3
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_NULL  = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

endpackage

FILE: sv/strict_priority_multi_fifo.sv
// strict priority multi-fifo top level: per-level pointers, slot memory and result stage
//
// One FIFO per priority level, all held in a single slot memory addressed by
// {level, slot}. A command is taken when start is high and busy is low; busy is
// only high during reset and in the first cycle after it, so a command can be
// issued every cycle. Each command gives exactly one result in the cycle after it is
// taken, on the cycle in which done is high; the result must be captured in that
// cycle. Dequeue and peek serve the highest-numbered non-empty level, found by a
// priority encoder over the per-level fill counters; the handle comes from the
// registered read port of the slot memory, which sets when the result appears.
// An enqueue written in one cycle is visible to a dequeue or peek taken in the
// next. Clear resets all pointers and counters at once; no clearing pass.
module strict_priority_multi_fifo #(
  parameter int LEVELS       = spmf_pkg::LEVELS_DEF,
  parameter int LEVEL_DEPTH  = spmf_pkg::LEVEL_DEPTH_DEF,
  parameter int HANDLE_WIDTH = spmf_pkg::HANDLE_WIDTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic [spmf_pkg::ACTION_W-1:0]      action,
  input  logic [spmf_pkg::LEVEL_W-1:0]       level,
  input  logic [spmf_pkg::HANDLE_IO_W-1:0]   handle_in,
  output logic                               done,
  output logic [spmf_pkg::HANDLE_IO_W-1:0]   handle_out,
  output logic                               found,
  output logic [spmf_pkg::STATUS_W-1:0]      status,
  output logic [spmf_pkg::TOTAL_IO_W-1:0]    total_count,
  output logic                               all_empty
);

  import spmf_pkg::*;

  localparam int LVL_W  = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int PTR_W  = (LEVEL_DEPTH > 1) ? $clog2(LEVEL_DEPTH) : 1;
  localparam int CNT_W  = $clog2(LEVEL_DEPTH + 1);
  localparam int TOT_W  = $clog2(LEVELS * LEVEL_DEPTH + 1);
  localparam int ADDR_W = LVL_W + PTR_W;

  logic [PTR_W-1:0] head [LEVELS];
  logic [PTR_W-1:0] tail [LEVELS];
  logic [CNT_W-1:0] fill [LEVELS];
  logic [TOT_W-1:0] entry_total;
  logic [TOT_W-1:0] entry_total_next;

  logic             accept;
  action_t          act;
  logic [LEVEL_CMP_W-1:0] level_wide;
  logic             in_range;
  logic [LVL_W-1:0] lvl_idx;
  logic [LVL_W-1:0] top_idx;
  logic             any_held;
  logic [LVL_W-1:0] sel;
  logic [HANDLE_WIDTH-1:0] handle_st;
  logic             enq_ok;
  logic             deq_ok;
  logic             rd_issue;
  status_t          status_next;
  logic [PTR_W-1:0] sel_head_inc;
  logic [PTR_W-1:0] sel_tail_inc;
  logic             sel_full;

  logic             rd_sel;
  status_t          status_q;
  logic [HANDLE_WIDTH-1:0] rd_data;

  assign accept     = start && !busy;
  assign act        = action_t'(action);
  assign level_wide = LEVEL_CMP_W'(level);
  assign in_range   = level_wide < LEVEL_CMP_W'(LEVELS);
  assign lvl_idx    = level_wide[LVL_W-1:0];
  assign handle_st  = HANDLE_WIDTH'(handle_in);

  // highest non-empty level wins
  always_comb begin
    any_held = 1'b0;
    top_idx  = '0;
    for (int i = 0; i < LEVELS; i++) begin
      if (fill[i] != '0) begin
        any_held = 1'b1;
        top_idx  = LVL_W'(i);
      end
    end
  end

  assign sel          = (act == ACT_ENQ) ? lvl_idx : top_idx;
  assign sel_full     = in_range && (fill[sel] == CNT_W'(LEVEL_DEPTH));
  assign sel_head_inc = (head[sel] == PTR_W'(LEVEL_DEPTH - 1)) ? '0 : head[sel] + 1'b1;
  assign sel_tail_inc = (tail[sel] == PTR_W'(LEVEL_DEPTH - 1)) ? '0 : tail[sel] + 1'b1;

  always_comb begin
    enq_ok           = 1'b0;
    deq_ok           = 1'b0;
    rd_issue         = 1'b0;
    status_next      = ST_OK;
    entry_total_next = entry_total;
    case (act)
      ACT_ENQ: begin
        if (handle_st == '0) begin
          status_next = ST_NULL;
        end else if (!in_range || sel_full) begin
          status_next = ST_FULL;
        end else begin
          enq_ok           = 1'b1;
          entry_total_next = entry_total + 1'b1;
        end
      end
      ACT_DEQ, ACT_PEEK: begin
        if (!any_held) begin
          status_next = ST_EMPTY;
        end else begin
          rd_issue = 1'b1;
          if (act == ACT_DEQ) begin
            deq_ok           = 1'b1;
            entry_total_next = entry_total - 1'b1;
          end
        end
      end
      ACT_CLEAR: begin
        entry_total_next = '0;
      end
      default: begin
        status_next = ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < LEVELS; i++) begin
        head[i] <= '0;
        tail[i] <= '0;
        fill[i] <= '0;
      end
      entry_total <= '0;
    end else if (accept) begin
      entry_total <= entry_total_next;
      if (act == ACT_CLEAR) begin
        for (int i = 0; i < LEVELS; i++) begin
          head[i] <= '0;
          tail[i] <= '0;
          fill[i] <= '0;
        end
      end else if (enq_ok) begin
        tail[sel] <= sel_tail_inc;
        fill[sel] <= fill[sel] + 1'b1;
      end else if (deq_ok) begin
        head[sel] <= sel_head_inc;
        fill[sel] <= fill[sel] - 1'b1;
      end
    end
  end

  spmf_slot_ram #(
    .ADDR_W (ADDR_W),
    .DATA_W (HANDLE_WIDTH)
  ) u_slot_ram (
    .clk   (clk),
    .we    (accept && enq_ok),
    .waddr ({sel, tail[sel]}),
    .wdata (handle_st),
    .re    (accept && rd_issue),
    .raddr ({sel, head[sel]}),
    .rdata (rd_data)
  );

  // result stage, lines up with the memory read data
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
      busy <= 1'b1;
    end else begin
      done <= accept;
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rd_sel   <= rd_issue;
      status_q <= status_next;
    end
  end

  assign handle_out  = rd_sel ? HANDLE_IO_W'(rd_data) : '0;
  assign found       = rd_sel;
  assign status      = status_q;
  assign total_count = TOTAL_IO_W'(entry_total);
  assign all_empty   = (entry_total == '0);

`ifndef NO_ASSERTIONS
  a_done_follows_beat: assert property (@(posedge clk) disable iff (rst)
    accept |=> done)
    else $error("accepted beat gave no result strobe");

  a_no_spurious_done: assert property (@(posedge clk) disable iff (rst)
    !accept |=> !done)
    else $error("result strobe without an accepted beat");

  a_found_is_ok: assert property (@(posedge clk) disable iff (rst)
    (done && found) |-> (status == ST_OK))
    else $error("found entry with a non-ok status");

  a_empty_no_handle: assert property (@(posedge clk) disable iff (rst)
    (done && status == ST_EMPTY) |-> (handle_out == '0 && !found))
    else $error("empty result carries a handle");

  a_total_matches_fill: assert property (@(posedge clk) disable iff (rst)
    any_held == (entry_total != '0))
    else $error("entry total disagrees with level fill counters");
`endif

endmodule

FILE: sv/spmf_slot_ram.sv
// handle storage: one write port, one registered read port
module spmf_slot_ram #(
  parameter int ADDR_W = 7,
  parameter int DATA_W = 16
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  localparam int DEPTH = 1 << ADDR_W;

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
